>>> sv/tost_pkg.sv
// ----------------------------------------------------------------------------
// tost_pkg
// Types, constants and helpers shared by the tagged object stream tokenizer.
// ----------------------------------------------------------------------------
package tost_pkg;

  localparam int LENGTH_BITS  = 32;
  localparam int HEADER_BYTES = 8;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam int MAX_EXT_N    = LENGTH_BITS / 8;
  localparam int EXT_BITS     = MAX_EXT_N * 8;
  localparam int REM_W        = EXT_BITS + 1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  object_tag;
    logic        object_start;
    logic        object_end;
    logic [63:0] decoded_value;
    logic        value_valid;
    logic [31:0] byte_offset;
    logic [2:0]  error_code;
  } out_item_t;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_TAG     = 7'b0000010,
    PH_EXT_TAG = 7'b0000100,
    PH_EXT_LEN = 7'b0001000,
    PH_OFFSET  = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_HEADER  = 3'd0,
    ROLE_TAG     = 3'd1,
    ROLE_EXT_TAG = 3'd2,
    ROLE_EXT_LEN = 3'd3,
    ROLE_OFFSET  = 3'd4,
    ROLE_PAYLOAD = 3'd5,
    ROLE_IGNORED = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_HEADER    = 3'd1,
    ERR_NOT_INT   = 3'd2,
    ERR_TOO_WIDE  = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_t;

  localparam logic [7:0] TAG_INT32   = 8'h22;
  localparam logic [7:0] TAG_UINT64  = 8'h23;
  localparam logic [7:0] TAG_FLOAT   = 8'hf0;
  localparam logic [7:0] TAG_FALSE   = 8'hb0;
  localparam logic [7:0] TAG_TRUE    = 8'hc0;
  localparam logic [7:0] TAG_NULL    = 8'he0;
  localparam logic [7:0] TAG_ARRAY   = 8'ha0;
  localparam logic [7:0] TAG_DICT    = 8'hd0;
  localparam logic [3:0] NIB_EXT     = 4'hf;
  localparam logic [3:0] NIB_INT     = 4'h1;
  localparam logic [3:0] NIB_UTF16   = 4'h6;

  // "bplist16"
  function automatic logic [7:0] magic_byte(input logic [HDR_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h62;
      3'd1:    b = 8'h70;
      3'd2:    b = 8'h6c;
      3'd3:    b = 8'h69;
      3'd4:    b = 8'h73;
      3'd5:    b = 8'h74;
      3'd6:    b = 8'h31;
      3'd7:    b = 8'h36;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> sv/tost_parser.sv
// ----------------------------------------------------------------------------
// tost_parser
// Parse state and per-byte classification. Computes the result for the
// presented item and updates state when the item is accepted.
// ----------------------------------------------------------------------------
module tost_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  tost_pkg::in_item_t  item,
  output tost_pkg::out_item_t res
);

  tost_pkg::phase_t                 phase_r, phase_nxt, phase_e;
  logic [tost_pkg::HDR_IDX_W-1:0]   hdr_r, hdr_nxt, hdr_e;
  logic [tost_pkg::REM_W-1:0]       rem_r, rem_nxt, rem_dec;
  logic [7:0]                       tag_r, tag_nxt;
  logic [63:0]                      acc_r, acc_nxt, acc_ins;
  logic [2:0]                       cnt_r, cnt_nxt;
  logic [2:0]                       idx_r, idx_nxt;
  logic [31:0]                      pos_r, pos_nxt, pos_e;
  tost_pkg::err_t                   err_r, err_nxt, err_e;
  logic                             clr;
  logic [7:0]                       b;
  logic [3:0]                       nib;

  assign b       = item.data_byte;
  assign nib     = b[3:0];
  assign clr     = item.first_byte || (phase_r == tost_pkg::PH_DONE);
  assign phase_e = clr ? tost_pkg::PH_HEADER : phase_r;
  assign hdr_e   = clr ? '0 : hdr_r;
  assign pos_e   = clr ? '0 : pos_r;
  assign err_e   = clr ? tost_pkg::ERR_NONE : err_r;
  assign acc_ins = acc_r | ({56'd0, b} << {idx_r, 3'b000});
  assign rem_dec = (rem_r != '0) ? rem_r - tost_pkg::REM_W'(1) : rem_r;

  always_comb begin
    phase_nxt = phase_e;
    hdr_nxt   = hdr_e;
    rem_nxt   = rem_r;
    tag_nxt   = tag_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_e + 32'd1;
    err_nxt   = err_e;

    res               = '0;
    res.byte_role     = tost_pkg::ROLE_IGNORED;
    res.byte_offset   = pos_e;

    if (err_e == tost_pkg::ERR_NONE) begin
      case (phase_e)
        tost_pkg::PH_HEADER: begin
          res.byte_role = tost_pkg::ROLE_HEADER;
          if (b != tost_pkg::magic_byte(hdr_e)) begin
            err_nxt = tost_pkg::ERR_HEADER;
          end else if (hdr_e == tost_pkg::HDR_IDX_W'(tost_pkg::HEADER_BYTES - 1)) begin
            hdr_nxt   = '0;
            phase_nxt = tost_pkg::PH_TAG;
          end else begin
            hdr_nxt = hdr_e + tost_pkg::HDR_IDX_W'(1);
          end
        end
        tost_pkg::PH_TAG: begin
          res.byte_role    = tost_pkg::ROLE_TAG;
          res.object_start = 1'b1;
          res.object_tag   = b;
          tag_nxt          = b;
          if (b == tost_pkg::TAG_ARRAY || b == tost_pkg::TAG_DICT) begin
            acc_nxt   = '0;
            idx_nxt   = '0;
            phase_nxt = tost_pkg::PH_OFFSET;
          end else if (b == tost_pkg::TAG_INT32) begin
            res.decoded_value = 64'd4;
            res.value_valid   = 1'b1;
            rem_nxt           = tost_pkg::REM_W'(4);
            phase_nxt         = tost_pkg::PH_PAYLOAD;
          end else if (b == tost_pkg::TAG_UINT64 || b == tost_pkg::TAG_FLOAT) begin
            res.decoded_value = 64'd8;
            res.value_valid   = 1'b1;
            rem_nxt           = tost_pkg::REM_W'(8);
            phase_nxt         = tost_pkg::PH_PAYLOAD;
          end else if (b == tost_pkg::TAG_FALSE || b == tost_pkg::TAG_TRUE ||
                       b == tost_pkg::TAG_NULL) begin
            res.value_valid = 1'b1;
            res.object_end  = 1'b1;
          end else if (nib == tost_pkg::NIB_EXT) begin
            phase_nxt = tost_pkg::PH_EXT_TAG;
          end else begin
            res.decoded_value = {60'd0, nib};
            res.value_valid   = 1'b1;
            if (nib == 4'd0) begin
              res.object_end = 1'b1;
            end else begin
              rem_nxt   = (b[7:4] == tost_pkg::NIB_UTF16) ?
                          tost_pkg::REM_W'({nib, 1'b0}) : tost_pkg::REM_W'(nib);
              phase_nxt = tost_pkg::PH_PAYLOAD;
            end
          end
        end
        tost_pkg::PH_EXT_TAG: begin
          res.byte_role  = tost_pkg::ROLE_EXT_TAG;
          res.object_tag = tag_r;
          if (b[7:4] != tost_pkg::NIB_INT) begin
            err_nxt = tost_pkg::ERR_NOT_INT;
          end else if (nib > 4'(tost_pkg::MAX_EXT_N)) begin
            err_nxt = tost_pkg::ERR_TOO_WIDE;
          end else if (nib == 4'd0) begin
            res.value_valid = 1'b1;
            res.object_end  = 1'b1;
            phase_nxt       = tost_pkg::PH_TAG;
          end else begin
            acc_nxt   = '0;
            cnt_nxt   = nib[2:0];
            idx_nxt   = '0;
            phase_nxt = tost_pkg::PH_EXT_LEN;
          end
        end
        tost_pkg::PH_EXT_LEN: begin
          res.byte_role  = tost_pkg::ROLE_EXT_LEN;
          res.object_tag = tag_r;
          acc_nxt        = acc_ins;
          idx_nxt        = idx_r + 3'd1;
          cnt_nxt        = (cnt_r != '0) ? cnt_r - 3'd1 : cnt_r;
          if (cnt_nxt == '0) begin
            res.decoded_value = acc_ins;
            res.value_valid   = 1'b1;
            if (acc_ins[tost_pkg::EXT_BITS-1:0] == '0) begin
              res.object_end = 1'b1;
              phase_nxt      = tost_pkg::PH_TAG;
            end else begin
              rem_nxt   = (tag_r[7:4] == tost_pkg::NIB_UTF16) ?
                          {acc_ins[tost_pkg::EXT_BITS-1:0], 1'b0} :
                          {1'b0, acc_ins[tost_pkg::EXT_BITS-1:0]};
              phase_nxt = tost_pkg::PH_PAYLOAD;
            end
          end
        end
        tost_pkg::PH_OFFSET: begin
          res.byte_role  = tost_pkg::ROLE_OFFSET;
          res.object_tag = tag_r;
          acc_nxt        = acc_ins;
          idx_nxt        = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            res.decoded_value = acc_ins;
            res.value_valid   = 1'b1;
            res.object_end    = 1'b1;
            phase_nxt         = tost_pkg::PH_TAG;
          end
        end
        tost_pkg::PH_PAYLOAD: begin
          res.byte_role  = tost_pkg::ROLE_PAYLOAD;
          res.object_tag = tag_r;
          rem_nxt        = rem_dec;
          if (rem_dec == '0) begin
            res.object_end = 1'b1;
            phase_nxt      = tost_pkg::PH_TAG;
          end
        end
        default: begin
          phase_nxt = tost_pkg::PH_HEADER;
        end
      endcase

      if (item.last_byte && err_nxt == tost_pkg::ERR_NONE) begin
        if (phase_nxt == tost_pkg::PH_HEADER) begin
          err_nxt = tost_pkg::ERR_HEADER;
        end else if (phase_nxt != tost_pkg::PH_TAG) begin
          err_nxt = tost_pkg::ERR_TRUNCATED;
        end else if (pos_e == 32'(tost_pkg::HEADER_BYTES - 1)) begin
          err_nxt = tost_pkg::ERR_TRUNCATED;
        end
      end
    end

    if (item.last_byte) begin
      phase_nxt = tost_pkg::PH_DONE;
    end
    res.error_code = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tost_pkg::PH_HEADER;
      hdr_r   <= '0;
      rem_r   <= '0;
      tag_r   <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      pos_r   <= '0;
      err_r   <= tost_pkg::ERR_NONE;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      rem_r   <= rem_nxt;
      tag_r   <= tag_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

>>> sv/tagged_object_stream_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// tagged_object_stream_tokenizer_unit
// Byte-serial tokenizer for tagged-object messages with an 8-byte header.
// Each accepted byte's result item is registered, in the skid register if the output is held.
// Throughput: 1 item per cycle while in_stall is low, set by the parse state update per accepted byte.
// A skid register keeps input acceptance going while one result waits.
// Reset (synchronous, active low) returns to header phase with no error.
// ----------------------------------------------------------------------------
module tagged_object_stream_tokenizer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tost_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tost_pkg::out_item_t out_item
);

  tost_pkg::out_item_t res;
  tost_pkg::out_item_t out_r, skid_r;
  logic                out_valid_r, skid_valid_r;
  logic                accept, out_fire;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  tost_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (!out_valid_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tagged object stream tokenizer. Messages are
// sent one byte per item; a behavioral parser predicts every result item,
// and results are compared field by field in arrival order. Directed
// messages cover header, scalar, container, extended-length and truncation
// cases, followed by random well-formed and damaged messages under random
// idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import tost_pkg::*;

  localparam int                STALL_LIMIT = 2000;
  localparam int                TOTAL_ITEMS = 1500;
  localparam logic [63:0]       HDR_TEXT    = "bplist16";

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  out_item_t   expected_tokens[$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int          rx_hold = 0;

  // parser state
  phase_t      prs_phase;
  logic [3:0]  prs_hdr_idx;
  logic [63:0] prs_remaining;
  logic [7:0]  prs_tag;
  logic [63:0] prs_len_acc;
  logic [3:0]  prs_len_cnt;
  logic [31:0] prs_pos;
  err_t        prs_err;
  int unsigned prs_shift;

  tagged_object_stream_tokenizer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  function automatic void clear_parse();
    prs_phase     = PH_HEADER;
    prs_hdr_idx   = '0;
    prs_remaining = '0;
    prs_tag       = '0;
    prs_len_acc   = '0;
    prs_len_cnt   = '0;
    prs_pos       = '0;
    prs_err       = ERR_NONE;
    prs_shift     = 0;
  endfunction

  function automatic out_item_t tokenize_byte(input in_item_t it);
    out_item_t   r;
    logic [7:0]  b;
    logic [63:0] need;
    bit          fixed;
    b = it.data_byte;
    r = '0;
    r.byte_role = ROLE_IGNORED;
    if (it.first_byte || prs_phase == PH_DONE) clear_parse();
    r.byte_offset = prs_pos;
    prs_pos = prs_pos + 32'd1;
    if (prs_err == ERR_NONE) begin
      case (prs_phase)
        PH_HEADER: begin
          r.byte_role = ROLE_HEADER;
          if (int'(prs_hdr_idx) >= HEADER_BYTES ||
              b != HDR_TEXT[63 - 8*int'(prs_hdr_idx) -: 8]) begin
            prs_err = ERR_HEADER;
          end else begin
            prs_hdr_idx = prs_hdr_idx + 4'd1;
            if (int'(prs_hdr_idx) == HEADER_BYTES) prs_phase = PH_TAG;
          end
        end
        PH_TAG: begin
          r.byte_role    = ROLE_TAG;
          r.object_start = 1'b1;
          r.object_tag   = b;
          prs_tag        = b;
          fixed          = 1'b1;
          case (b)
            TAG_INT32:                     need = 64'd4;
            TAG_UINT64, TAG_FLOAT:         need = 64'd8;
            TAG_FALSE, TAG_TRUE, TAG_NULL: need = 64'd0;
            default: begin
              fixed = 1'b0;
              need  = (b[7:4] == NIB_UTF16) ? 64'(b[3:0]) << 1 : 64'(b[3:0]);
            end
          endcase
          if (b == TAG_ARRAY || b == TAG_DICT) begin
            prs_len_acc = '0;
            prs_len_cnt = '0;
            prs_phase   = PH_OFFSET;
          end else if (b[3:0] == NIB_EXT) begin
            prs_phase = PH_EXT_TAG;
          end else begin
            r.decoded_value = fixed ? need : 64'(b[3:0]);
            r.value_valid   = 1'b1;
            if (need == 0) begin
              r.object_end = 1'b1;
            end else begin
              prs_remaining = need;
              prs_phase     = PH_PAYLOAD;
            end
          end
        end
        PH_EXT_TAG: begin
          r.byte_role  = ROLE_EXT_TAG;
          r.object_tag = prs_tag;
          if (b[7:4] != NIB_INT) begin
            prs_err = ERR_NOT_INT;
          end else if (int'(b[3:0]) * 8 > LENGTH_BITS) begin
            prs_err = ERR_TOO_WIDE;
          end else if (b[3:0] == 4'd0) begin
            r.value_valid = 1'b1;
            r.object_end  = 1'b1;
            prs_phase     = PH_TAG;
          end else begin
            prs_len_acc = '0;
            prs_len_cnt = b[3:0];
            prs_shift   = 0;
            prs_phase   = PH_EXT_LEN;
          end
        end
        PH_EXT_LEN: begin
          r.byte_role  = ROLE_EXT_LEN;
          r.object_tag = prs_tag;
          if (prs_shift < 64) prs_len_acc = prs_len_acc | (64'(b) << prs_shift);
          prs_shift = prs_shift + 8;
          if (prs_len_cnt > 0) prs_len_cnt = prs_len_cnt - 4'd1;
          if (prs_len_cnt == 0) begin
            need = (prs_tag[7:4] == NIB_UTF16) ? prs_len_acc << 1 : prs_len_acc;
            r.decoded_value = prs_len_acc;
            r.value_valid   = 1'b1;
            if (need == 0) begin
              r.object_end = 1'b1;
              prs_phase    = PH_TAG;
            end else begin
              prs_remaining = need;
              prs_phase     = PH_PAYLOAD;
            end
          end
        end
        PH_OFFSET: begin
          r.byte_role  = ROLE_OFFSET;
          r.object_tag = prs_tag;
          prs_len_acc  = prs_len_acc | (64'(b) << {prs_len_cnt[2:0], 3'b000});
          prs_len_cnt  = prs_len_cnt + 4'd1;
          if (prs_len_cnt >= 4'd8) begin
            r.decoded_value = prs_len_acc;
            r.value_valid   = 1'b1;
            r.object_end    = 1'b1;
            prs_len_cnt     = '0;
            prs_phase       = PH_TAG;
          end
        end
        default: begin
          r.byte_role  = ROLE_PAYLOAD;
          r.object_tag = prs_tag;
          if (prs_remaining > 0) prs_remaining = prs_remaining - 64'd1;
          if (prs_remaining == 0) begin
            r.object_end = 1'b1;
            prs_phase    = PH_TAG;
          end
        end
      endcase
      if (it.last_byte && prs_err == ERR_NONE) begin
        if (prs_phase == PH_HEADER) prs_err = ERR_HEADER;
        else if (prs_phase != PH_TAG) prs_err = ERR_TRUNCATED;
        else if (r.byte_offset == 32'(HEADER_BYTES - 1)) prs_err = ERR_TRUNCATED;
      end
    end
    if (it.last_byte) prs_phase = PH_DONE;
    r.error_code = prs_err;
    return r;
  endfunction

  // message builders
  function automatic void push_header(ref logic [7:0] q[$]);
    for (int i = 0; i < HEADER_BYTES; i++) q.push_back(HDR_TEXT[63 - 8*i -: 8]);
  endfunction

  function automatic void push_fill(ref logic [7:0] q[$], input int n, input logic [7:0] v);
    repeat (n) q.push_back(v);
  endfunction

  function automatic void push_random(ref logic [7:0] q[$], input int n);
    repeat (n) q.push_back(8'($urandom));
  endfunction

  function automatic void push_object(ref logic [7:0] q[$]);
    logic [3:0]  hi;
    logic [3:0]  lo;
    int          n;
    logic [31:0] ext_len;
    case ($urandom_range(5, 0))
      0: begin
        case ($urandom_range(5, 0))
          0: begin q.push_back(TAG_INT32);  push_random(q, 4); end
          1: begin q.push_back(TAG_UINT64); push_random(q, 8); end
          2: begin q.push_back(TAG_FLOAT);  push_random(q, 8); end
          3: q.push_back(TAG_FALSE);
          4: q.push_back(TAG_TRUE);
          default: q.push_back(TAG_NULL);
        endcase
      end
      1: begin
        q.push_back($urandom_range(1, 0) ? TAG_ARRAY : TAG_DICT);
        push_random(q, 8);
      end
      2, 3: begin
        hi = 4'($urandom);
        lo = 4'($urandom_range(14, 0));
        if (hi == 4'h2 && (lo == 4'h2 || lo == 4'h3)) lo = 4'h4;
        if (lo == 4'h0 && hi >= 4'ha) hi = NIB_UTF16;
        q.push_back({hi, lo});
        push_random(q, (hi == NIB_UTF16) ? 2 * int'(lo) : int'(lo));
      end
      default: begin
        hi      = ($urandom_range(2, 0) == 0) ? NIB_UTF16 : 4'($urandom);
        n       = $urandom_range(MAX_EXT_N, 0);
        ext_len = (n == 0) ? 32'd0 : 32'($urandom_range(24, 0));
        q.push_back({hi, NIB_EXT});
        q.push_back({NIB_INT, 4'(n)});
        for (int i = 0; i < n; i++) q.push_back(ext_len[8*i +: 8]);
        push_random(q, (hi == NIB_UTF16) ? 2 * int'(ext_len) : int'(ext_len));
      end
    endcase
  endfunction

  function automatic void build_message(ref logic [7:0] q[$], input int objects);
    q.delete();
    push_header(q);
    repeat (objects) push_object(q);
  endfunction

  // sender
  task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
    int       gap;
    in_item_t it;
    gap = tx_idle ? $urandom_range(13, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.data_byte  = b;
    it.first_byte = is_first;
    it.last_byte  = is_last;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    expected_tokens.push_back(tokenize_byte(it));
    bytes_sent++;
  endtask

  task automatic send_message(input logic [7:0] q[$], input bit mark_first, input bit mark_last);
    foreach (q[i]) send_byte(q[i], mark_first && i == 0, mark_last && i == q.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  // receiver
  initial begin : result_sink
    int gap;
    out_stall <= 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = rx_idle ? $urandom_range(13, 0) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : check_tokens
    out_item_t exp_tok;
    string     bad;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at offset %0d", out_item.byte_offset);
      end else begin
        exp_tok = expected_tokens.pop_front();
        bad = "";
        if (out_item.byte_role     !== exp_tok.byte_role)     bad = {bad, " byte_role"};
        if (out_item.object_tag    !== exp_tok.object_tag)    bad = {bad, " object_tag"};
        if (out_item.object_start  !== exp_tok.object_start)  bad = {bad, " object_start"};
        if (out_item.object_end    !== exp_tok.object_end)    bad = {bad, " object_end"};
        if (out_item.decoded_value !== exp_tok.decoded_value) bad = {bad, " decoded_value"};
        if (out_item.value_valid   !== exp_tok.value_valid)   bad = {bad, " value_valid"};
        if (out_item.byte_offset   !== exp_tok.byte_offset)   bad = {bad, " byte_offset"};
        if (out_item.error_code    !== exp_tok.error_code)    bad = {bad, " error_code"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at offset %0d:%s", exp_tok.byte_offset, bad);
            $display("  exp role=%0d tag=%h st=%b end=%b val=%h vv=%b off=%0d err=%0d",
                     exp_tok.byte_role, exp_tok.object_tag, exp_tok.object_start,
                     exp_tok.object_end, exp_tok.decoded_value, exp_tok.value_valid,
                     exp_tok.byte_offset, exp_tok.error_code);
            $display("  got role=%0d tag=%h st=%b end=%b val=%h vv=%b off=%0d err=%0d",
                     out_item.byte_role, out_item.object_tag, out_item.object_start,
                     out_item.object_end, out_item.decoded_value, out_item.value_valid,
                     out_item.byte_offset, out_item.error_code);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // tests
  task automatic test_header();
    logic [7:0] q[$];
    q.delete(); push_header(q);
    send_message(q, 1'b1, 1'b1);                       // no root object
    while (q.size() > 3) void'(q.pop_back());
    send_message(q, 1'b1, 1'b1);                       // ends inside header
    q.delete(); push_header(q); q[4] = 8'h58; push_fill(q, 2, 8'h00);
    send_message(q, 1'b1, 1'b1);                       // bad magic, rest ignored
    q.delete(); push_header(q); q.push_back(TAG_NULL);
    send_message(q, 1'b0, 1'b1);                       // new message without first flag
  endtask

  task automatic test_scalars();
    logic [7:0] q[$];
    q.delete(); push_header(q);
    q.push_back(TAG_INT32);  push_fill(q, 4, 8'hff);
    q.push_back(TAG_UINT64); push_fill(q, 8, 8'hff);
    q.push_back(TAG_FLOAT);  push_fill(q, 8, 8'h00);
    q.push_back(TAG_FALSE);
    q.push_back(TAG_TRUE);
    q.push_back(TAG_NULL);
    q.push_back(8'h10);
    q.push_back(8'h5e); push_random(q, 14);
    q.push_back(8'h60);
    q.push_back(8'h63); push_random(q, 6);
    send_message(q, 1'b1, 1'b1);
  endtask

  task automatic test_containers();
    logic [7:0] q[$];
    q.delete(); push_header(q);
    q.push_back(TAG_ARRAY); push_fill(q, 8, 8'hff);
    q.push_back(TAG_DICT);  push_fill(q, 8, 8'h00);
    q.push_back(TAG_TRUE);
    send_message(q, 1'b1, 1'b1);
  endtask

  task automatic test_ext_length();
    logic [7:0] q[$];
    q.delete(); push_header(q);
    q.push_back(8'h5f); q.push_back(8'h10);                  // zero-byte length
    q.push_back(8'h6f); q.push_back(8'h11); q.push_back(8'h02); push_random(q, 4);
    q.push_back(8'h4f); q.push_back(8'h14); q.push_back(8'h03); push_fill(q, 3, 8'h00);
    push_random(q, 3);
    send_message(q, 1'b1, 1'b1);
    q.delete(); push_header(q);
    q.push_back(8'h8f); q.push_back(8'h14); push_fill(q, 4, 8'hff); push_random(q, 2);
    send_message(q, 1'b1, 1'b1);                             // huge length, truncated
    q.delete(); push_header(q);
    q.push_back(8'h5f); q.push_back(8'h20); q.push_back(8'h00);
    send_message(q, 1'b1, 1'b1);                             // marker not an integer
    q.delete(); push_header(q);
    q.push_back(8'hff); q.push_back(8'h15);
    send_message(q, 1'b1, 1'b1);                             // length too wide
  endtask

  task automatic test_truncation();
    logic [7:0] q[$];
    q.delete(); push_header(q);
    q.push_back(TAG_INT32); push_random(q, 2);
    send_message(q, 1'b1, 1'b1);
    q.delete(); push_header(q);
    q.push_back(TAG_DICT); push_random(q, 3);
    send_message(q, 1'b1, 1'b1);
    q.delete(); push_header(q);
    q.push_back(TAG_INT32); push_random(q, 2);
    send_message(q, 1'b1, 1'b0);                             // abandoned mid-object
    q.delete(); push_header(q); q.push_back(TAG_TRUE);
    send_message(q, 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    logic [7:0] q[$];
    wait_drained();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 80;
    build_message(q, 6);
    send_message(q, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_messages();
    logic [7:0] q[$];
    int         cut;
    while (bytes_sent < TOTAL_ITEMS) begin
      if ($urandom_range(5, 0) == 0) begin
        tx_idle = $urandom_range(1, 0);
        rx_idle = $urandom_range(1, 0);
      end
      build_message(q, $urandom_range(6, 1));
      case ($urandom_range(9, 0))
        0: begin
          q[$urandom_range(q.size() - 1, 0)] = 8'($urandom);
          send_message(q, 1'b1, 1'b1);
        end
        1: begin
          cut = $urandom_range(q.size() - 1, 1);
          while (q.size() > cut) void'(q.pop_back());
          send_message(q, 1'b1, 1'b1);
        end
        2: begin
          q.push_back({4'($urandom), NIB_EXT});
          q.push_back($urandom_range(1, 0) ? {NIB_INT, 4'($urandom)} : 8'($urandom));
          push_random(q, $urandom_range(6, 0));
          send_message(q, 1'b1, 1'b1);
        end
        3: begin
          repeat ($urandom_range(12, 1))
            send_byte(8'($urandom), $urandom_range(7, 0) == 0, $urandom_range(7, 0) == 0);
        end
        4: begin
          cut = $urandom_range(q.size() - 1, 1);
          while (q.size() > cut) void'(q.pop_back());
          send_message(q, 1'b1, 1'b0);
        end
        default: send_message(q, $urandom_range(3, 0) != 0, 1'b1);
      endcase
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    in_item  <= '0;
    rst_n    <= 1'b0;
    clear_parse();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header();
    test_scalars();
    test_containers();
    test_ext_length();
    test_truncation();
    test_backpressure();
    test_random_messages();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
